/* rtl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/dws_pkg.sv */
// shared constants, types and arithmetic helpers of the wave stencil step
package dws_pkg;
    localparam int MaxCols  = 1024;
    localparam int MaxRows  = 1024;
    localparam int FracBits = 24;
    localparam int ColW     = $clog2(MaxCols);
    localparam int RowW     = $clog2(MaxRows);
    localparam int CntW     = ColW + 1;
    localparam int RcntW    = RowW + 1;
    localparam int CfgW     = 31;
    localparam int CfgIdxW  = 2;
    localparam logic [31:0] StepReset = 32'((64'd1 << FracBits) / 100);

    typedef enum logic [CfgIdxW-1:0] {
        REG_DAMPING   = 2'd0,
        REG_STEP_SIZE = 2'd1,
        REG_GRID_COLS = 2'd2,
        REG_GRID_ROWS = 2'd3
    } t_reg_idx;

    // operation codes of the shared multiplier
    typedef enum logic [1:0] {
        OP_CV = 2'd0,
        OP_VN = 2'd1,
        OP_UN = 2'd2
    } t_mul_op;

    // which of up to three results a slot computes
    typedef enum logic [1:0] {
        SLOT_ABOVE = 2'd0,
        SLOT_LEFT  = 2'd1,
        SLOT_HERE  = 2'd2
    } t_slot;

    // commands from controller to datapath
    typedef struct packed {
        logic  capture;     // take input beat and read line buffers
        logic  load_slot;   // set up the operands of one result
        t_slot slot;
        logic  lap;         // form laplacian
        logic  mul;         // start multiply
        t_mul_op op;
        logic  fin;         // finish multiply step
        logic  wr_back;     // write line buffers and advance counters
        logic  emit;        // load the output register
        logic  last;        // run_last of the emitted result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic has_above;
        logic has_left;
        logic has_here;
        logic out_busy;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction
endpackage

/* rtl/dws_ctrl.sv */
// controller state machine of the wave stencil step
module dws_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dws_pkg::t_sts   i_sts,
    output dws_pkg::t_cmd   o_cmd
);
    import dws_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SEL, S_LOAD, S_LAP, S_M1, S_F1, S_M2, S_F2, S_M3, S_F3,
        S_EMIT, S_WB
    } t_state;

    t_state r_state;
    t_slot  r_slot;
    logic   r_has_l, r_has_h;

    assign o_ready = (r_state == S_IDLE);

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE: o_cmd.capture = i_valid;
            S_LOAD: o_cmd.load_slot = 1'b1;
            S_LAP:  o_cmd.lap = 1'b1;
            S_M1:   begin o_cmd.mul = 1'b1; o_cmd.op = OP_CV; end
            S_F1:   begin o_cmd.fin = 1'b1; o_cmd.op = OP_CV; end
            S_M2:   begin o_cmd.mul = 1'b1; o_cmd.op = OP_VN; end
            S_F2:   begin o_cmd.fin = 1'b1; o_cmd.op = OP_VN; end
            S_M3:   begin o_cmd.mul = 1'b1; o_cmd.op = OP_UN; end
            S_F3:   begin o_cmd.fin = 1'b1; o_cmd.op = OP_UN; end
            S_EMIT: begin
                o_cmd.emit = !i_sts.out_busy;
                o_cmd.last = (r_slot == SLOT_HERE) ||
                             (r_slot == SLOT_LEFT && !r_has_h) ||
                             (r_slot == SLOT_ABOVE && !r_has_l && !r_has_h);
            end
            S_WB:   o_cmd.wr_back = 1'b1;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= SLOT_ABOVE;
            r_has_l <= 1'b0;
            r_has_h <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_READ;
                S_READ: r_state <= S_SEL;
                S_SEL: begin
                    r_has_l <= i_sts.has_left;
                    r_has_h <= i_sts.has_here;
                    priority if (i_sts.has_above) begin
                        r_slot <= SLOT_ABOVE; r_state <= S_LOAD;
                    end else if (i_sts.has_left) begin
                        r_slot <= SLOT_LEFT; r_state <= S_LOAD;
                    end else if (i_sts.has_here) begin
                        r_slot <= SLOT_HERE; r_state <= S_LOAD;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_LOAD: r_state <= S_LAP;
                S_LAP:  r_state <= S_M1;
                S_M1:   r_state <= S_F1;
                S_F1:   r_state <= S_M2;
                S_M2:   r_state <= S_F2;
                S_F2:   r_state <= S_M3;
                S_M3:   r_state <= S_F3;
                S_F3:   r_state <= S_EMIT;
                S_EMIT: if (!i_sts.out_busy) begin
                    priority if (r_slot == SLOT_ABOVE && r_has_l) begin
                        r_slot <= SLOT_LEFT; r_state <= S_LOAD;
                    end else if (r_slot != SLOT_HERE && r_has_h) begin
                        r_slot <= SLOT_HERE; r_state <= S_LOAD;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_WB:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/dws_dp.sv */
// datapath: line buffers, counters, stencil and shared multiplier
module dws_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dws_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [dws_pkg::CfgW-1:0]      i_cfg_data,
    input  logic signed [31:0]            i_disp_in,
    input  logic signed [31:0]            i_vel_in,
    input  dws_pkg::t_cmd                 i_cmd,
    output dws_pkg::t_sts                 o_sts,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_disp_out,
    output logic signed [31:0]            o_vel_out,
    output logic [9:0]                    o_out_row,
    output logic [9:0]                    o_out_col,
    output logic                          o_run_last,
    output logic                          o_grid_last
);
    import dws_pkg::*;

    // configuration registers
    logic [30:0] r_damp, r_dt;
    logic [10:0] r_cols, r_rows;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp <= '0;
            r_dt   <= StepReset[30:0];
            r_cols <= 11'(MaxCols);
            r_rows <= 11'(MaxRows);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DAMPING:   r_damp <= i_cfg_data;
                REG_STEP_SIZE: r_dt   <= i_cfg_data;
                REG_GRID_COLS: r_cols <= i_cfg_data[10:0];
                REG_GRID_ROWS: r_rows <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [CntW-1:0]  cols_e;
    logic [RcntW-1:0] rows_e;
    always_comb begin
        cols_e = (r_cols == '0) ? CntW'(1) :
                 (r_cols > 11'(MaxCols)) ? CntW'(MaxCols) : CntW'(r_cols);
        rows_e = (r_rows == '0) ? RcntW'(1) :
                 (r_rows > 11'(MaxRows)) ? RcntW'(MaxRows) : RcntW'(r_rows);
    end

    // position counters
    logic [RcntW-1:0] r_row;
    logic [CntW-1:0]  r_col;
    logic [ColW-1:0]  j;
    logic row_end, last_row, r_gt0, r_gt1, j_gt0, j_gt1, rt_ok;
    assign j        = r_col[ColW-1:0];
    assign row_end  = ({1'b0, r_col} + 1'b1) >= {1'b0, cols_e};
    assign last_row = ({1'b0, r_row} + 1'b1) >= {1'b0, rows_e};
    assign r_gt0    = r_row != '0;
    assign r_gt1    = r_row > RcntW'(1);
    assign j_gt0    = j != '0;
    assign j_gt1    = j > ColW'(1);
    assign rt_ok    = !row_end && (j != {ColW{1'b1}});

    // captured input and held neighbours
    logic signed [31:0] r_du, r_dv, r_h0, r_h1, r_h2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0 <= '0; r_h1 <= '0; r_h2 <= '0;
        end else if (i_cmd.wr_back) begin
            r_h2 <= r_h0; r_h0 <= r_du; r_h1 <= r_dv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_du <= i_disp_in; r_dv <= i_vel_in;
        end
    end

    // line buffers, read in the capture cycle and the cycle after it
    logic signed [31:0] disp_mem [2*MaxCols];
    logic signed [31:0] vel_mem  [MaxCols];
    logic [ColW:0] cur_base, prv_base;
    logic [ColW-1:0] jm1, jp1;
    assign cur_base = {r_row[0], {ColW{1'b0}}};
    assign prv_base = {~r_row[0], {ColW{1'b0}}};
    assign jm1 = j - 1'b1;
    assign jp1 = j + 1'b1;

    logic r_rd;
    logic signed [31:0] r_pc, r_pl, r_pr, r_cu, r_pv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
        end else begin
            r_rd <= i_cmd.capture;
        end
    end
    // two displacement reads per cycle: centre and above first, then the
    // left and right neighbours of the row above
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pc <= disp_mem[prv_base + {1'b0, j}];
            r_cu <= disp_mem[cur_base + {1'b0, j}];
            r_pv <= vel_mem[j];
        end
        if (r_rd) begin
            r_pl <= disp_mem[prv_base + {1'b0, jm1}];
            r_pr <= disp_mem[prv_base + {1'b0, jp1}];
        end
        if (i_cmd.wr_back) begin
            disp_mem[cur_base + {1'b0, j}] <= r_du;
            vel_mem[j] <= r_dv;
        end
    end

    // counter update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0; r_col <= '0;
        end else if (i_cmd.wr_back) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // slot operand selection
    logic signed [31:0] r_u, r_v, r_up, r_dn, r_lf, r_rt;
    logic [9:0] r_orow, r_ocol;
    logic r_glast;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_slot) begin
            unique case (i_cmd.slot)
                SLOT_ABOVE: begin
                    r_u <= r_pc; r_v <= r_pv; r_dn <= r_du;
                    r_up <= r_gt1 ? r_cu : r_pc;
                    r_lf <= j_gt0 ? r_pl : r_pc;
                    r_rt <= rt_ok ? r_pr : r_pc;
                    r_orow <= 10'(r_row - 1'b1); r_ocol <= 10'(j); r_glast <= 1'b0;
                end
                SLOT_LEFT: begin
                    r_u <= r_h0; r_v <= r_h1; r_dn <= r_h0; r_rt <= r_du;
                    r_lf <= j_gt1 ? r_h2 : r_h0;
                    r_up <= r_gt0 ? r_pl : r_h0;
                    r_orow <= 10'(r_row); r_ocol <= 10'(jm1); r_glast <= 1'b0;
                end
                SLOT_HERE: begin
                    r_u <= r_du; r_v <= r_dv; r_dn <= r_du; r_rt <= r_du;
                    r_lf <= j_gt0 ? r_h0 : r_du;
                    r_up <= r_gt0 ? r_pc : r_du;
                    r_orow <= 10'(r_row); r_ocol <= 10'(j); r_glast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.has_above = r_gt0;
    assign o_sts.has_left  = last_row && j_gt0;
    assign o_sts.has_here  = last_row && row_end;
    assign o_sts.out_busy  = o_valid && !i_ready;

    // laplacian, then shared multiplier with registered product
    logic signed [31:0] r_lap, r_d, r_vn, r_un;
    logic signed [63:0] r_prod;
    logic signed [31:0] mul_b, rnd_q;
    logic [30:0] mul_a;
    logic signed [35:0] lap_sum;
    logic signed [63:0] prnd;
    assign lap_sum = 36'(r_up) + 36'(r_dn) + 36'(r_lf) + 36'(r_rt) - (36'(r_u) <<< 2);
    always_comb begin
        unique case (i_cmd.op)
            OP_CV:   begin mul_a = r_damp; mul_b = r_v;  end
            OP_VN:   begin mul_a = r_dt;   mul_b = r_d;  end
            OP_UN:   begin mul_a = r_dt;   mul_b = r_vn; end
            default: begin mul_a = r_dt;   mul_b = r_vn; end
        endcase
        prnd  = r_prod + (64'sd1 <<< (FracBits - 1));
        rnd_q = sat32(36'(prnd >>> FracBits) == (prnd >>> FracBits) ?
                      36'(prnd >>> FracBits) :
                      (prnd[63] ? -36'sd2147483649 : 36'sd2147483648));
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.lap) r_lap <= sat32(lap_sum);
        if (i_cmd.mul) r_prod <= $signed({33'b0, mul_a}) * 64'(mul_b);
        if (i_cmd.fin) begin
            unique case (i_cmd.op)
                OP_CV: r_d  <= sat32(36'(r_lap) - 36'(rnd_q));
                OP_VN: r_vn <= sat32(36'(r_v) + 36'(rnd_q));
                OP_UN: r_un <= sat32(36'(r_u) + 36'(rnd_q));
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_disp_out <= r_un; o_vel_out <= r_vn;
            o_out_row <= r_orow; o_out_col <= r_ocol;
            o_run_last <= i_cmd.last; o_grid_last <= r_glast;
        end
    end
endmodule

/* rtl/damped_wave_stencil_step.sv */
// top level of the damped wave stencil step
// Usage: cells enter in raster order on the input channel (i_valid/o_ready,
// fields i_disp_in and i_vel_in). Each accepted beat yields zero to three
// result beats on the output channel (o_valid/i_ready): the cell one row
// above, and on the last row also the cell to the left and at the row end.
// o_run_last marks the final result of an input beat, o_grid_last the final
// cell of the grid. The user must write registers through i_cfg_we/
// i_cfg_idx/i_cfg_data only while the block is idle; the block itself does
// not enforce this. Sequence: each input beat passes read, select and
// write-back states; each result adds load, laplacian, three multiply/finish
// pairs and emit, as the single shared multiplier takes its products in turn.
// Reset (synchronous, active low) clears counters, neighbour registers and
// configuration to defaults; line buffer contents stay undefined until a
// full row has been written.
// When the receiver stalls, the result is held in the output register and the
// controller waits before loading the next one; after the last result of a
// beat the next input beat may be taken while that result still waits.
module damped_wave_stencil_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dws_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [dws_pkg::CfgW-1:0]     i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [31:0]           i_disp_in,
    input  logic signed [31:0]           i_vel_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_disp_out,
    output logic signed [31:0]           o_vel_out,
    output logic [9:0]                   o_out_row,
    output logic [9:0]                   o_out_col,
    output logic                         o_run_last,
    output logic                         o_grid_last
);
    import dws_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller
    dws_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    // datapath
    dws_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_disp_in(i_disp_in), .i_vel_in(i_vel_in),
        .i_cmd(cmd), .o_sts(sts), .o_valid(o_valid), .i_ready(i_ready),
        .o_disp_out(o_disp_out), .o_vel_out(o_vel_out), .o_out_row(o_out_row),
        .o_out_col(o_out_col), .o_run_last(o_run_last), .o_grid_last(o_grid_last)
    );
endmodule

/* rtl/dws_checker.sv */
// port-level checker of the wave stencil step and its bind
`include "assert_macros.svh"
module dws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_run_last,
    input logic       o_grid_last,
    input logic [9:0] o_out_col
);
    // a result beat stays until taken
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // grid end is always the end of a run
    `ASSERT_IMPL(a_glast_run, i_clk, i_rst_n, o_valid && o_grid_last, o_run_last)
    // a waiting result keeps its column
    `ASSERT_NEXT(a_col_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_out_col))
    // an input beat is never followed at once by another ready
    `ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
endmodule

bind damped_wave_stencil_step dws_checker u_dws_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_run_last(o_run_last),
    .o_grid_last(o_grid_last), .o_out_col(o_out_col)
);
